FILE: rtl/usvg_pkg.sv
// Package for the UV sphere vertex generator: register indexes, count limits
// and the sine polynomial coefficients. No dependencies.
package usvg_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_SECTORS = 2'd1;
	localparam logic [1:0] REG_STACKS  = 2'd2;

	// Reset values of the registers.
	localparam logic [23:0] RADIUS_RST  = 24'd256;
	localparam logic [8:0]  SECTORS_RST = 9'd36;
	localparam logic [8:0]  STACKS_RST  = 9'd18;

	// Limits applied to the counts before use.
	localparam int MAX_SECTORS = 256;
	localparam int MAX_STACKS  = 256;
	localparam logic [8:0] MIN_SECTORS = 9'd3;
	localparam logic [8:0] MIN_STACKS  = 9'd2;

	// Odd Taylor coefficients of sin(x*pi/2), Q30.
	localparam logic [30:0] CO1 = 31'd1686629713;
	localparam logic [30:0] CO3 = 31'd693598668;
	localparam logic [30:0] CO5 = 31'd85569306;
	localparam logic [30:0] CO7 = 31'd5026995;
	localparam logic [30:0] CO9 = 31'd172272;

	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [61:0] RND_Q30  = 62'h2000_0000;

	// Side information that travels with each beat through the pipeline.
	typedef struct packed {
		logic        oor;
		logic [16:0] vnum;
	} side_t;

endpackage

FILE: rtl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator top level: a pipeline from grid
// indexes to position, normal and vertex number. Depends on usvg_pkg.
//
// Usage:
// The slave stream carries one grid point per beat (stack and sector index).
// The master stream returns one vertex per beat, in input order, with the
// out_of_range flag on tuser. Configuration registers (radius, sector count,
// stack count) are written through the cfg channel, which is always ready;
// write them only while the pipeline is empty.
// Throughput is one beat per cycle while the master side keeps up. The pipeline
// has one input stage, PHASE_BITS + 1 divider stages that form the two angle
// phases one quotient bit each, and ten stages for the sine polynomial, the
// trig products, the radius scaling and the output register. The Horner chain
// of the sine polynomial sets most of that tail.
// The whole pipeline advances together: when the master side stalls with a
// vertex waiting in the output register, every stage holds and s_axis_tready
// drops, so nothing is lost or repeated. It accepts a new beat whenever the
// output register is empty or is being taken in the same cycle.
// Asynchronous reset empties the pipeline and restores the register defaults
// (radius 1.0, 36 sectors, 18 stacks).
module uv_sphere_vertex_generator #(
	parameter int PHASE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: stack_index[8:0], sector_index[17:9], zero pad [23:18]
	input  logic [23:0]  s_axis_tdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: pos_x[24:0], pos_y[49:25], pos_z[74:50], norm_x[90:75],
	// norm_y[106:91], norm_z[122:107], vertex_number[139:123], zero pad [143:140]
	output logic [143:0] m_axis_tdata,
	// tuser: out_of_range[0]
	output logic         m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	localparam int PB  = PHASE_BITS;
	localparam int NW  = PB + 9;       // dividend width
	localparam int QW  = PB + 1;       // quotient width (in-range quotients)
	localparam int ND  = PB + 1;       // divider stages
	localparam int LAT = PB + 12;      // total stages, output included
	localparam int S3  = ND + 1;       // index of the fold stage
	localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);

	// Configuration registers.
	logic [23:0] radius_q;
	logic [8:0]  sectors_q;
	logic [8:0]  stacks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= usvg_pkg::RADIUS_RST;
			sectors_q <= usvg_pkg::SECTORS_RST;
			stacks_q  <= usvg_pkg::STACKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				usvg_pkg::REG_RADIUS:  radius_q  <= cfg_data;
				usvg_pkg::REG_SECTORS: sectors_q <= cfg_data[8:0];
				usvg_pkg::REG_STACKS:  stacks_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Counts clamped to legal range; user must keep them static while items are in flight (not enforced).
	logic [8:0] secs_c, stks_c;

	always_comb begin
		if (sectors_q < usvg_pkg::MIN_SECTORS) secs_c = usvg_pkg::MIN_SECTORS;
		else if (32'(sectors_q) > usvg_pkg::MAX_SECTORS) secs_c = 9'(usvg_pkg::MAX_SECTORS);
		else secs_c = sectors_q;
		if (stacks_q < usvg_pkg::MIN_STACKS) stks_c = usvg_pkg::MIN_STACKS;
		else if (32'(stacks_q) > usvg_pkg::MAX_STACKS) stks_c = 9'(usvg_pkg::MAX_STACKS);
		else stks_c = stacks_q;
	end

	// Global advance: every stage moves when the output register can move.
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic            vld_s  [0:LAT-1];
	usvg_pkg::side_t side_s [0:LAT-1];

	// Stage 1: dividends for both phases, range check and vertex number.
	// The side information shifts along with the data from here on.
	logic [8:0]  in_i, in_j;
	logic [NW-1:0] rst_p [0:ND];
	logic [NW-1:0] rse_p [0:ND];
	logic [QW-1:0] qst_p [0:ND];
	logic [QW-1:0] qse_p [0:ND];
	logic [18:0] vnum_full;

	assign in_i      = s_axis_tdata[8:0];
	assign in_j      = s_axis_tdata[17:9];
	assign vnum_full = 19'(in_i) * 19'({1'b0, secs_c} + 10'd1) + 19'(in_j);

	always_ff @(posedge clk) begin
		if (en) begin
			rst_p[0]     <= (NW'(in_i) << (PB - 1)) + NW'(stks_c >> 1);
			rse_p[0]     <= (NW'(in_j) << PB) + NW'(secs_c >> 1);
			qst_p[0]     <= '0;
			qse_p[0]     <= '0;
			side_s[0].oor  <= (in_i > stks_c) || (in_j > secs_c);
			side_s[0].vnum <= vnum_full[16:0];
			for (int n = 1; n < LAT; n++) side_s[n] <= side_s[n-1];
		end
	end

	// Divider stages: one quotient bit per stage, most significant first.
	for (genvar d = 0; d < ND; d++) begin : g_div
		localparam int B = PB - d;
		logic [NW-1:0] dst, dse;
		assign dst = NW'(stks_c) << B;
		assign dse = NW'(secs_c) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rst_p[d] >= dst) begin
					rst_p[d+1] <= rst_p[d] - dst;
					qst_p[d+1] <= qst_p[d] | (QW'(1) << B);
				end else begin
					rst_p[d+1] <= rst_p[d];
					qst_p[d+1] <= qst_p[d];
				end
				if (rse_p[d] >= dse) begin
					rse_p[d+1] <= rse_p[d] - dse;
					qse_p[d+1] <= qse_p[d] | (QW'(1) << B);
				end else begin
					rse_p[d+1] <= rse_p[d];
					qse_p[d+1] <= qse_p[d];
				end
			end
		end
	end

	// Phases of the four sine lanes: sin and cos of stack, sin and cos of sector.
	logic [PB-1:0] st_ph, se_ph;
	logic [PB-1:0] lane_ph [0:3];
	assign st_ph      = QUARTER - qst_p[ND][PB-1:0];
	assign se_ph      = qse_p[ND][PB-1:0];
	assign lane_ph[0] = st_ph;
	assign lane_ph[1] = st_ph + QUARTER;
	assign lane_ph[2] = se_ph;
	assign lane_ph[3] = se_ph + QUARTER;

	logic [30:0] mag_s9 [0:3];
	logic        sgn_s9 [0:3];

	for (genvar l = 0; l < 4; l++) begin : g_sin
		logic [1:0]  quad;
		logic [30:0] xs, xf;
		logic [30:0] x_p   [0:5];
		logic        neg_p [0:5];
		logic [30:0] x2_p  [0:3];
		logic [30:0] t_p   [0:3];
		logic [61:0] sq, m0, m1, m2, m3, fin;

		assign quad = lane_ph[l][PB-1:PB-2];
		assign xs   = 31'(lane_ph[l][PB-3:0]) << (32 - PB);
		assign xf   = quad[0] ? (usvg_pkg::Q30_ONE - xs) : xs;
		assign sq   = 62'(x_p[0]) * 62'(x_p[0]);
		assign m0   = 62'(x2_p[0]) * 62'(usvg_pkg::CO9);
		assign m1   = 62'(x2_p[1]) * 62'(t_p[0]);
		assign m2   = 62'(x2_p[2]) * 62'(t_p[1]);
		assign m3   = 62'(x2_p[3]) * 62'(t_p[2]);
		assign fin  = 62'(x_p[5]) * 62'(t_p[3]);

		always_ff @(posedge clk) begin
			if (en) begin
				x_p[0]   <= xf;
				neg_p[0] <= quad[1];
				for (int n = 1; n < 6; n++) begin
					x_p[n]   <= x_p[n-1];
					neg_p[n] <= neg_p[n-1];
				end
				x2_p[0] <= sq[60:30];
				for (int n = 1; n < 4; n++) x2_p[n] <= x2_p[n-1];
				t_p[0] <= usvg_pkg::CO7 - m0[60:30];
				t_p[1] <= usvg_pkg::CO5 - m1[60:30];
				t_p[2] <= usvg_pkg::CO3 - m2[60:30];
				t_p[3] <= usvg_pkg::CO1 - m3[60:30];
				// Polynomial may overshoot 1.0 slightly near the peak.
				mag_s9[l] <= (fin[61:30] > 32'(usvg_pkg::Q30_ONE)) ? usvg_pkg::Q30_ONE
				                                                     : fin[60:30];
				sgn_s9[l] <= neg_p[5];
			end
		end
	end

	// Stage 10: unit normal in Q30, rounded magnitudes.
	logic [30:0] nxm_s10, nym_s10, nzm_s10;
	logic        nxs_s10, nys_s10, nzs_s10;
	logic [61:0] pxp, pyp;
	assign pxp = 62'(mag_s9[1]) * 62'(mag_s9[3]) + usvg_pkg::RND_Q30;
	assign pyp = 62'(mag_s9[1]) * 62'(mag_s9[2]) + usvg_pkg::RND_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			nxm_s10 <= pxp[60:30];
			nym_s10 <= pyp[60:30];
			nzm_s10 <= mag_s9[0];
			nxs_s10 <= sgn_s9[1] ^ sgn_s9[3];
			nys_s10 <= sgn_s9[1] ^ sgn_s9[2];
			nzs_s10 <= sgn_s9[0];
		end
	end

	// Stage 11: radius scaling and Q1.15 rounding, still sign and magnitude.
	logic [24:0] pxm_s11, pym_s11, pzm_s11;
	logic [15:0] qxm_s11, qym_s11, qzm_s11;
	logic        sx_s11, sy_s11, sz_s11;
	logic [61:0] rx, ry, rz;
	logic [30:0] hx, hy, hz;
	assign rx = 62'(radius_q) * 62'(nxm_s10) + usvg_pkg::RND_Q30;
	assign ry = 62'(radius_q) * 62'(nym_s10) + usvg_pkg::RND_Q30;
	assign rz = 62'(radius_q) * 62'(nzm_s10) + usvg_pkg::RND_Q30;
	assign hx = nxm_s10 + 31'h4000;
	assign hy = nym_s10 + 31'h4000;
	assign hz = nzm_s10 + 31'h4000;

	always_ff @(posedge clk) begin
		if (en) begin
			pxm_s11 <= rx[54:30];
			pym_s11 <= ry[54:30];
			pzm_s11 <= rz[54:30];
			qxm_s11 <= hx[30:15];
			qym_s11 <= hy[30:15];
			qzm_s11 <= hz[30:15];
			sx_s11  <= nxs_s10;
			sy_s11  <= nys_s10;
			sz_s11  <= nzs_s10;
		end
	end

	// Stage 12: output register with sign applied and out-of-range zeroing.
	function automatic logic [15:0] q15(input logic s, input logic [15:0] m);
		logic [15:0] r;
		if (s) r = 16'(-m);
		else if (m > 16'h7FFF) r = 16'h7FFF;
		else r = m;
		return r;
	endfunction

	usvg_pkg::side_t side_pre;
	logic [24:0] ox, oy, oz;
	logic [15:0] ux, uy, uz;
	assign side_pre = side_s[LAT-2];
	assign ox = sx_s11 ? 25'(-pxm_s11) : pxm_s11;
	assign oy = sy_s11 ? 25'(-pym_s11) : pym_s11;
	assign oz = sz_s11 ? 25'(-pzm_s11) : pzm_s11;
	assign ux = q15(sx_s11, qxm_s11);
	assign uy = q15(sy_s11, qym_s11);
	assign uz = q15(sz_s11, qzm_s11);

	logic [143:0] tdata_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_pre.oor) tdata_s12 <= '0;
			else tdata_s12 <= {4'd0, side_pre.vnum, uz, uy, ux, oz, oy, ox};
		end
	end

	// Valid bits shift with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < LAT; n++) vld_s[n] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_axis_tvalid;
			for (int n = 1; n < LAT; n++) vld_s[n] <= vld_s[n-1];
		end
	end

	assign m_axis_tvalid = vld_s[LAT-1];
	assign m_axis_tdata  = tdata_s12;
	assign m_axis_tuser  = side_s[LAT-1].oor;

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("out-of-range vertex carries nonzero data");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT-2] && en |=> m_axis_tvalid)
		else $error("beat lost before output register");
	a_fold_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S3-1] && en |=> vld_s[S3])
		else $error("beat lost between divider and sine stages");
`endif

endmodule
